>>> rtl/pfp_pkg.sv
// Package for the polygon fan point-in-polygon block: field widths, defaults,
// item kinds, datapath command and status types, controller states.
// No dependencies.
`timescale 1ns / 1ps
package pfp_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 24;
  localparam int unsigned POS_W            = 24;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned COUNT_W          = 9;
  localparam int unsigned HULL_MIN         = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ORIGIN = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_QUERY  = 2'd3
  } pfp_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_WR_ORIGIN,
    OP_APPEND,
    OP_POP,
    OP_MUL1,
    OP_MUL2_COL,
    OP_MUL2_EDGE,
    OP_EDGE_CMP,
    OP_EDGE_NEXT,
    OP_BOX_UPD,
    OP_SET_OK,
    OP_EMIT
  } pfp_op_e;

  // read address sources
  typedef enum logic [2:0] {
    AD_CM1,    // count - 1
    AD_CM2,    // count - 2
    AD_BASE,   // first hull vertex
    AD_BASE1,  // second hull vertex
    AD_IDX,    // raw index
    AD_HIDX,   // hull base + index
    AD_HIDX1   // hull base + index + 1
  } pfp_addr_e;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_A,
    LD_B,
    LD_C
  } pfp_ld_e;

  typedef struct packed {
    logic      rd;
    pfp_addr_e addr;
    pfp_ld_e   ld;
    pfp_op_e   op;
    logic      idx_clr;
    logic      idx_inc;
  } pfp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_ge2;
    logic h_gt3;
    logic h_zero;
    logic box_out;
    logic idx_eq_cnt;
    logic idx_last;
    logic eq_last;
    logic col;
    logic straddle;
    logic out_free;
  } pfp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ORIGIN,
    S_ADD0,
    S_ADD1,
    S_ADD2,
    S_ADD3,
    S_ADD4,
    S_ADD5,
    S_APPEND,
    S_CM_CHK,
    S_CM_LA,
    S_CM_LB,
    S_CM_LC,
    S_CM_M1,
    S_CM_M2,
    S_CM_DEC,
    S_BOX0,
    S_BOXRD,
    S_BOXUP,
    S_Q0,
    S_QJ,
    S_QI,
    S_QM1,
    S_QM2,
    S_QC,
    S_QN,
    S_EMIT
  } pfp_state_e;

endpackage

>>> rtl/pfp_if.sv
// Stream interfaces of the point-in-polygon block: input items, results and
// the configuration write channel. Depends on pfp_pkg.
`timescale 1ns / 1ps
interface pfp_in_if;
  logic                      valid;
  logic                      ready;
  logic [pfp_pkg::KIND_W-1:0] kind;
  logic [pfp_pkg::POS_W-1:0]  pos_x;
  logic [pfp_pkg::POS_W-1:0]  pos_y;
  modport source (output valid, kind, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

interface pfp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        inside_res;
  logic                        commit_ok;
  logic [pfp_pkg::COUNT_W-1:0] vertex_count;
  logic                        store_full;
  modport source (output valid, inside_res, commit_ok, vertex_count, store_full,
                  input ready);
  modport sink   (input valid, inside_res, commit_ok, vertex_count, store_full,
                  output ready);
endinterface

interface pfp_cfg_if;
  logic valid;
  logic ready;
  logic closed_mode;
  modport source (output valid, closed_mode, input ready);
  modport sink   (input valid, closed_mode, output ready);
endinterface

>>> rtl/pfp_datapath.sv
// Datapath: vertex memory, point registers, shared multiplier, count, box
// and result registers. Driven by pfp_ctrl commands. Depends on pfp_pkg.
`timescale 1ns / 1ps
module pfp_datapath #(
  parameter int unsigned MAX_VERTICES = pfp_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pfp_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfp_pkg::pfp_cmd_t           cmd_i,
  output pfp_pkg::pfp_status_t        status_o,
  input  logic [pfp_pkg::POS_W-1:0]   pos_x_i,
  input  logic [pfp_pkg::POS_W-1:0]   pos_y_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_closed_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        inside_res_o,
  output logic                        commit_ok_o,
  output logic [pfp_pkg::COUNT_W-1:0] vertex_count_o,
  output logic                        store_full_o
);
  import pfp_pkg::*;

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned MW   = CW + 2;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned RW   = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned XW   = (CNTW > COUNT_W) ? CNTW : COUNT_W;

  logic [2*CW-1:0] mem [MAX_VERTICES];
  logic [2*CW-1:0] rdata_q;
  logic signed [CW-1:0] rd_x, rd_y;

  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [CW-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic signed [PW-1:0] s_q, p_q, prod;
  logic [CNTW-1:0] cnt_q, idx_q, hsz, base, rd_sel;
  logic            closed_q, inside_q, ok_q, full_q;
  logic            out_valid_q, out_inside_q, out_ok_q, out_full_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic [XW-1:0]   cnt_ext;
  logic [RW-1:0]   in_x_ext, in_y_ext;
  logic            cnt_full, we;
  logic [AW-1:0]   waddr;

  logic signed [MW-1:0] dx_ba, dy_ca, dx_ca, dy_ba, dabs, mul_a, mul_b;
  logic                 dneg, nn_neg, edge_hit;

  assign rd_x = rdata_q[CW-1:0];
  assign rd_y = rdata_q[2*CW-1:CW];

  // low COORD_BITS of the raw field, zero-extended first when wider
  assign in_x_ext = RW'(pos_x_i);
  assign in_y_ext = RW'(pos_y_i);

  assign base = CNTW'(!closed_q);
  assign hsz  = closed_q ? cnt_q : ((cnt_q == '0) ? '0 : cnt_q - CNTW'(1));

  always_comb begin
    case (cmd_i.addr)
      AD_CM1:   rd_sel = cnt_q - CNTW'(1);
      AD_CM2:   rd_sel = cnt_q - CNTW'(2);
      AD_BASE:  rd_sel = base;
      AD_BASE1: rd_sel = base + CNTW'(1);
      AD_IDX:   rd_sel = idx_q;
      AD_HIDX:  rd_sel = base + idx_q;
      AD_HIDX1: rd_sel = base + idx_q + CNTW'(1);
      default:  rd_sel = idx_q;
    endcase
  end

  assign cnt_full = (cnt_q == CNTW'(MAX_VERTICES));
  assign we    = (cmd_i.op == OP_WR_ORIGIN) || ((cmd_i.op == OP_APPEND) && !cnt_full);
  assign waddr = (cmd_i.op == OP_WR_ORIGIN) ? '0 : cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {cy_q, cx_q};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_sel[AW-1:0]];
    end
  end

  // shared multiplier operands
  assign dx_ba = MW'(bx_q) - MW'(ax_q);
  assign dy_ca = MW'(cy_q) - MW'(ay_q);
  assign dx_ca = MW'(cx_q) - MW'(ax_q);
  assign dy_ba = MW'(by_q) - MW'(ay_q);
  assign dneg  = dy_ba[MW-1];
  assign dabs  = dneg ? -dy_ba : dy_ba;
  // sign of the numerator once the divisor is made positive
  assign nn_neg = (s_q != '0) && (s_q[PW-1] ^ dneg);

  always_comb begin
    case (cmd_i.op)
      OP_MUL2_COL: begin
        mul_a = dx_ca;
        mul_b = dy_ba;
      end
      OP_MUL2_EDGE: begin
        mul_a = dx_ca + MW'(!nn_neg);
        mul_b = dabs;
      end
      default: begin
        mul_a = dx_ba;
        mul_b = dy_ca;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign edge_hit = s_q[PW-1] ? (s_q > p_q) : (s_q >= p_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.ld)
      LD_A: begin
        ax_q <= rd_x;
        ay_q <= rd_y;
      end
      LD_B: begin
        bx_q <= rd_x;
        by_q <= rd_y;
      end
      LD_C: begin
        cx_q <= rd_x;
        cy_q <= rd_y;
      end
      default: ;
    endcase
    if (cmd_i.op == OP_START) begin
      cx_q <= in_x_ext[CW-1:0];
      cy_q <= in_y_ext[CW-1:0];
    end
    if (cmd_i.op == OP_EDGE_NEXT) begin
      bx_q <= ax_q;
      by_q <= ay_q;
    end
    if (cmd_i.op == OP_MUL1) begin
      s_q <= prod;
    end
    if (cmd_i.op == OP_MUL2_COL) begin
      p_q <= prod;
    end
    if (cmd_i.op == OP_MUL2_EDGE) begin
      p_q <= prod;
      s_q <= dneg ? -s_q : s_q;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CNTW'(1);
    end
    case (cmd_i.op)
      OP_START: begin
        inside_q <= 1'b0;
        ok_q     <= 1'b0;
        full_q   <= 1'b0;
      end
      OP_APPEND:   full_q   <= cnt_full;
      OP_SET_OK:   ok_q     <= 1'b1;
      OP_EDGE_CMP: inside_q <= inside_q ^ edge_hit;
      default: ;
    endcase
    if (cmd_i.op == OP_EMIT) begin
      out_inside_q <= inside_q;
      out_ok_q     <= ok_q;
      out_full_q   <= full_q;
      out_cnt_q    <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign cnt_ext = XW'(cnt_q);

  // architectural state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      closed_q    <= 1'b1;
      minx_q      <= '0;
      maxx_q      <= '0;
      miny_q      <= '0;
      maxy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        closed_q <= cfg_closed_i;
      end
      case (cmd_i.op)
        OP_WR_ORIGIN: cnt_q <= CNTW'(1);
        OP_APPEND: begin
          if (!cnt_full) begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        OP_POP: cnt_q <= cnt_q - CNTW'(1);
        OP_BOX_UPD: begin
          if (idx_q == CNTW'(1)) begin
            minx_q <= rd_x;
            maxx_q <= rd_x;
            miny_q <= rd_y;
            maxy_q <= rd_y;
          end else begin
            if (rd_x < minx_q) minx_q <= rd_x;
            if (rd_x > maxx_q) maxx_q <= rd_x;
            if (rd_y < miny_q) miny_q <= rd_y;
            if (rd_y > maxy_q) maxy_q <= rd_y;
          end
        end
        default: ;
      endcase
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.cnt_ge2    = (cnt_q >= CNTW'(2));
    status_o.h_gt3      = (hsz > CNTW'(HULL_MIN));
    status_o.h_zero     = (hsz == '0);
    status_o.box_out    = (cx_q < minx_q) || (cx_q > maxx_q) ||
                          (cy_q < miny_q) || (cy_q > maxy_q);
    status_o.idx_eq_cnt = (idx_q == cnt_q);
    status_o.idx_last   = (({1'b0, idx_q} + (CNTW+1)'(1)) == {1'b0, hsz});
    status_o.eq_last    = (bx_q == cx_q) && (by_q == cy_q);
    status_o.col        = (s_q == p_q);
    status_o.straddle   = (rd_y > cy_q) != (by_q > cy_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign inside_res_o   = out_inside_q;
  assign commit_ok_o    = out_ok_q;
  assign store_full_o   = out_full_q;
  assign vertex_count_o = out_cnt_q;

endmodule

>>> rtl/pfp_ctrl.sv
// Controller state machine: sequences add, commit, bounding box and query
// walks over the datapath. Depends on pfp_pkg.
`timescale 1ns / 1ps
module pfp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [pfp_pkg::KIND_W-1:0]  in_kind_i,
  output logic                        in_ready_o,
  input  pfp_pkg::pfp_status_t        status_i,
  output pfp_pkg::pfp_cmd_t           cmd_o
);
  import pfp_pkg::*;

  pfp_state_e state_q, state_d;
  logic       sec_q, sec_d;
  pfp_kind_e  kind;

  assign kind = pfp_kind_e'(in_kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    sec_d         = sec_q;
    in_ready_o    = 1'b0;
    cmd_o.rd      = 1'b0;
    cmd_o.addr    = AD_IDX;
    cmd_o.ld      = LD_NONE;
    cmd_o.op      = OP_NONE;
    cmd_o.idx_clr = 1'b0;
    cmd_o.idx_inc = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op      = OP_START;
          cmd_o.idx_clr = 1'b1;
          case (kind)
            KIND_ORIGIN: state_d = S_ORIGIN;
            KIND_ADD:    state_d = S_ADD0;
            KIND_COMMIT: state_d = S_CM_CHK;
            default:     state_d = S_Q0;
          endcase
        end
      end
      S_ORIGIN: begin
        cmd_o.op = OP_WR_ORIGIN;
        state_d  = S_EMIT;
      end
      S_ADD0: begin
        if (status_i.cnt_zero) begin
          cmd_o.op = OP_WR_ORIGIN;
          state_d  = S_EMIT;
        end else begin
          cmd_o.rd   = 1'b1;
          cmd_o.addr = AD_CM1;
          state_d    = S_ADD1;
        end
      end
      S_ADD1: begin
        cmd_o.ld   = LD_B;
        cmd_o.rd   = status_i.cnt_ge2;
        cmd_o.addr = AD_CM2;
        state_d    = S_ADD2;
      end
      S_ADD2: begin
        if (status_i.eq_last) begin
          state_d = S_EMIT;
        end else if (!status_i.cnt_ge2) begin
          state_d = S_APPEND;
        end else begin
          cmd_o.ld = LD_A;
          state_d  = S_ADD3;
        end
      end
      S_ADD3: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_ADD4;
      end
      S_ADD4: begin
        cmd_o.op = OP_MUL2_COL;
        state_d  = S_ADD5;
      end
      S_ADD5: begin
        state_d = status_i.col ? S_EMIT : S_APPEND;
      end
      S_APPEND: begin
        cmd_o.op = OP_APPEND;
        state_d  = S_EMIT;
      end
      S_CM_CHK: begin
        sec_d = 1'b0;
        if (status_i.h_gt3) begin
          cmd_o.rd   = 1'b1;
          cmd_o.addr = AD_CM2;
          state_d    = S_CM_LA;
        end else begin
          state_d = S_BOX0;
        end
      end
      S_CM_LA: begin
        cmd_o.ld   = LD_A;
        cmd_o.rd   = 1'b1;
        cmd_o.addr = sec_q ? AD_BASE : AD_CM1;
        state_d    = S_CM_LB;
      end
      S_CM_LB: begin
        cmd_o.ld   = LD_B;
        cmd_o.rd   = 1'b1;
        cmd_o.addr = sec_q ? AD_BASE1 : AD_BASE;
        state_d    = S_CM_LC;
      end
      S_CM_LC: begin
        cmd_o.ld = LD_C;
        state_d  = S_CM_M1;
      end
      S_CM_M1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_CM_M2;
      end
      S_CM_M2: begin
        cmd_o.op = OP_MUL2_COL;
        state_d  = S_CM_DEC;
      end
      S_CM_DEC: begin
        if (status_i.col) begin
          cmd_o.op = OP_POP;
          state_d  = S_CM_CHK;
        end else if (!sec_q) begin
          sec_d      = 1'b1;
          cmd_o.rd   = 1'b1;
          cmd_o.addr = AD_CM1;
          state_d    = S_CM_LA;
        end else begin
          cmd_o.op = OP_SET_OK;
          state_d  = S_BOX0;
        end
      end
      S_BOX0: begin
        cmd_o.idx_clr = 1'b1;
        state_d       = status_i.cnt_zero ? S_EMIT : S_BOXRD;
      end
      S_BOXRD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.addr    = AD_IDX;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_BOXUP;
      end
      S_BOXUP: begin
        cmd_o.op = OP_BOX_UPD;
        state_d  = status_i.idx_eq_cnt ? S_EMIT : S_BOXRD;
      end
      S_Q0: begin
        if (status_i.box_out || status_i.h_zero) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd   = 1'b1;
          cmd_o.addr = AD_CM1;
          state_d    = S_QJ;
        end
      end
      S_QJ: begin
        cmd_o.ld   = LD_B;
        cmd_o.rd   = 1'b1;
        cmd_o.addr = AD_HIDX;
        state_d    = S_QI;
      end
      S_QI: begin
        cmd_o.ld = LD_A;
        state_d  = status_i.straddle ? S_QM1 : S_QN;
      end
      S_QM1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_QM2;
      end
      S_QM2: begin
        cmd_o.op = OP_MUL2_EDGE;
        state_d  = S_QC;
      end
      S_QC: begin
        cmd_o.op = OP_EDGE_CMP;
        state_d  = S_QN;
      end
      S_QN: begin
        cmd_o.op      = OP_EDGE_NEXT;
        cmd_o.idx_inc = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.addr    = AD_HIDX1;
        state_d       = status_i.idx_last ? S_EMIT : S_QI;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/polygon_fan_point_in_polygon_top.sv
// Top level of the polygon fan point-in-polygon block: controller, datapath
// and port interfaces. Depends on pfp_pkg, pfp_if, pfp_ctrl, pfp_datapath.
`timescale 1ns / 1ps
// Keeps a polygon of up to MAX_VERTICES vertices in a single-port-read
// memory and answers one result transaction for every input transaction.
// Kinds: origin (restart the store with this vertex), add (append unless it
// repeats the last vertex or is collinear with the last two; refused and
// flagged when the store is full), commit (pop wrapped spikes off the hull
// end while more than three hull points remain, then rebuild the bounding
// box) and query (inclusive box test, then crossing-number parity over the
// hull edges; the truncating quotient test is done with two multiplies, no
// divider). closed_mode=1 puts vertex 0 in the hull, 0 leaves it out; write
// it only while the block is idle. One item is worked at a time; the result
// register lets the next item be taken while a result waits. Work is paced
// by the memory read port and the one shared multiplier: a commit grows with
// each popped vertex and each stored vertex of the box, a query with each
// hull edge and each edge that crosses the query row. No clearing pass
// after reset.
module polygon_fan_point_in_polygon_top #(
  parameter int unsigned MAX_VERTICES = pfp_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pfp_pkg::COORD_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  pfp_in_if.sink    in_i,
  pfp_out_if.source out_o,
  pfp_cfg_if.sink   cfg_i
);
  import pfp_pkg::*;

  pfp_cmd_t    cmd;
  pfp_status_t status;

  // configuration writes land at once
  assign cfg_i.ready = 1'b1;

  pfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pos_x_i        (in_i.pos_x),
    .pos_y_i        (in_i.pos_y),
    .cfg_we_i       (cfg_i.valid),
    .cfg_closed_i   (cfg_i.closed_mode),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .inside_res_o   (out_o.inside_res),
    .commit_ok_o    (out_o.commit_ok),
    .vertex_count_o (out_o.vertex_count),
    .store_full_o   (out_o.store_full)
  );

  // one item in flight: no second transaction right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in work");

  // at most one of the result flags per result transaction
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot0({out_o.inside_res, out_o.commit_ok, out_o.store_full}))
    else $error("result flags overlap");

  // a refused add only happens with the store at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.store_full) |->
      (out_o.vertex_count == COUNT_W'(MAX_VERTICES)))
    else $error("store_full with store not at capacity");

  // commit succeeds only with a hull of four or more points
  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.commit_ok && (MAX_VERTICES < 512)) |->
      (out_o.vertex_count > COUNT_W'(HULL_MIN)))
    else $error("commit_ok with too few vertices");

endmodule
